// ===== hdl/lrt_pkg.sv =====
// Shared types, widths, constants and the arctangent table of the lidar ring and time tagger.
// Used by every module in this folder; depends on nothing.
package lrt_pkg;

  localparam int COORD_BITS_DEF   = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CW    = 36;
  localparam int ZW    = 22;
  localparam int OW    = 25;
  localparam int NW    = 48;
  localparam int DW    = 23;
  localparam int QB    = 21;
  localparam int TW    = 21;
  localparam int RW    = 6;
  localparam int CFG_W = 23;
  localparam int MW    = 33;

  localparam logic signed [ZW-1:0] Z_HALF_PI = 22'sd102944;

  localparam logic signed [OW-1:0] O_HALF_PI   = 25'sd102944;
  localparam logic signed [OW-1:0] O_PI        = 25'sd205887;
  localparam logic signed [OW-1:0] O_3HALF_PI  = 25'sd308831;
  localparam logic signed [OW-1:0] O_2PI       = 25'sd411775;

  localparam logic signed [MW-1:0] DEG_PER_RAD = 33'sd3754936;
  localparam logic signed [31:0]   DEG_M883    = -32'sd578683;
  localparam logic signed [31:0]   DEG_M2433   = -32'sd1594491;
  localparam logic signed [31:0]   DEG_2       = 32'sd131072;

  localparam logic [1:0] RING_16  = 2'd0;
  localparam logic [1:0] RING_32  = 2'd1;
  localparam logic [1:0] RING_64  = 2'd2;
  localparam logic [1:0] RING_OFF = 2'd3;

  localparam logic signed [TW-1:0] T_MAX = 21'sd1048575;
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_RING_MODE = 3'd0,
    CFG_START_AZ  = 3'd1,
    CFG_END_AZ    = 3'd2,
    CFG_PERIOD    = 3'd3,
    CFG_MIN_RANGE = 3'd4,
    CFG_MAX_RANGE = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQ_MN, S_SQ_MX, S_RANGE, S_SQRT,
    S_ELEV, S_DEG, S_RING, S_AZ, S_UNWRAP, S_TMUL, S_TCHK, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cordic_req_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd51472;
      5'd1:  v = 17'd30386;
      5'd2:  v = 17'd16055;
      5'd3:  v = 17'd8150;
      5'd4:  v = 17'd4091;
      5'd5:  v = 17'd2047;
      5'd6:  v = 17'd1024;
      5'd7:  v = 17'd512;
      5'd8:  v = 17'd256;
      5'd9:  v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lrt_mult.sv =====
// Shared signed multiplier with a registered product.
// Depends on lrt_pkg for the operand width.
module lrt_mult import lrt_pkg::*; (
  input  logic                   clk,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hdl/lrt_cordic.sv =====
// Iterative vectoring CORDIC giving atan2(y, x) in Q16 radians, one step per cycle.
// Depends on lrt_pkg for widths, the request struct and the arctangent table.
module lrt_cordic import lrt_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_req_t          req,
  output logic                 done,
  output logic signed [ZW-1:0] z
);

  localparam int CNT_W = $clog2(STEPS);

  logic                 active;
  logic [CNT_W-1:0]     cnt;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] da;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign da = $signed({{(ZW-17){1'b0}}, atan_q16(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (req.x == '0 && req.y == '0) begin
          z      <= '0;
          x      <= '0;
          y      <= '0;
          done   <= 1'b1;
          active <= 1'b0;
        end else begin
          active <= 1'b1;
          if (req.x < 0) begin
            if (req.y >= 0) begin
              x <= req.y;
              y <= -req.x;
              z <= Z_HALF_PI;
            end else begin
              x <= -req.y;
              y <= req.x;
              z <= -Z_HALF_PI;
            end
          end else begin
            x <= req.x;
            y <= req.y;
            z <= '0;
          end
        end
      end else if (active) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + da;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - da;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lrt_isqrt.sv =====
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
// Depends on lrt_pkg for the common import only.
module lrt_isqrt import lrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic        active;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= n;
        res    <= '0;
        bitv   <= 64'h4000_0000_0000_0000;
      end else if (active) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lrt_div.sv =====
// Restoring divider for magnitudes, one quotient bit per cycle; the quotient must fit QB bits.
// Depends on lrt_pkg for the dividend, divisor and quotient widths.
module lrt_div import lrt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QB-1:0] q
);

  localparam int CNT_W = $clog2(QB);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= num;
        dsh    <= NW'({den, {(QB-1){1'b0}}});
        q      <= '0;
      end else if (active) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          q   <= {q[QB-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QB - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lidar_ring_and_time_tagger_unit.sv =====
// Lidar ring and time tagger: range filter, elevation to ring, azimuth to point time.
// Each kept point takes a 32-step square root, two CORDIC passes and the shared multiplier,
// plus a 21-step divide unless the time saturates or the azimuth span is zero.
// One request is worked at a time: the input is ready only in S_IDLE, and output stalls hold
// S_OUT. A point dropped by range, by ring mode off or by ring goes back to S_IDLE unsent.
// Synchronous active-high reset clears control state, half-sweep flag and config registers.
module lidar_ring_and_time_tagger_unit import lrt_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int IN_W  = ((3*COORD_BITS + 16 + 7) / 8) * 8,
  localparam int OUT_F = 3*COORD_BITS + 16 + RW + TW,
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // px, py, pz, intensity_in
  input  logic             s_tuser,   // sweep_start
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // qx, qy, qz, intensity_out, ring, time_us
);

  localparam int CB = COORD_BITS;
  localparam int SH = (COORD_BITS < 31) ? (31 - COORD_BITS) : 0;

  logic [1:0]        ring_mode;
  logic signed [21:0] start_az;
  logic signed [21:0] end_az;
  logic [19:0]       period;
  logic [22:0]       min_range;
  logic [22:0]       max_range;

  state_t state;
  state_t state_next;

  logic signed [CB-1:0] px_r;
  logic signed [CB-1:0] py_r;
  logic signed [CB-1:0] pz_r;
  logic [15:0]          inten_r;
  logic                 half_passed;
  logic [63:0]          rxy;
  logic [63:0]          zz;
  logic [63:0]          mnsq;
  logic [RW-1:0]        ring_r;
  logic signed [OW-1:0] diff;
  logic                 neg_r;
  logic signed [TW-1:0] t_r;

  logic signed [CB-1:0] oqx;
  logic signed [CB-1:0] oqy;
  logic signed [CB-1:0] oqz;
  logic [15:0]          ointen;
  logic [RW-1:0]        oring;
  logic signed [TW-1:0] otime;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] prod;

  logic        sqrt_start;
  logic        sqrt_done;
  logic [31:0] rho;
  cordic_req_t creq;
  logic        c_done;
  logic signed [ZW-1:0] c_z;
  logic        div_start;
  logic        div_done;
  logic [QB-1:0] div_q;

  logic s_fire;
  logic out_free;
  logic range_keep;
  logic ring_ok;
  logic signed [31:0] ring_val;
  logic signed [OW-1:0] ori_u;
  logic hp_next;
  logic signed [DW-1:0] den;
  logic [DW-1:0] den_mag;
  logic signed [NW-1:0] num;
  logic [NW-1:0] num_mag;
  logic t_sat;
  logic signed [TW:0] q_signed;
  logic signed [TW-1:0] q_final;

  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  function automatic logic signed [31:0] tdiv(input logic signed [31:0] v, input logic [4:0] k);
    logic signed [31:0] adj;
    adj = (v < 0) ? v + ((32'sd1 <<< k) - 32'sd1) : v;
    return adj >>> k;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_mode <= RING_16;
      start_az  <= '0;
      end_az    <= 22'sd411775;
      period    <= 20'd100000;
      min_range <= 23'd1000;
      max_range <= 23'd1000000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RING_MODE: ring_mode <= cfg_wdata[1:0];
        CFG_START_AZ:  start_az  <= $signed(cfg_wdata[21:0]);
        CFG_END_AZ:    end_az    <= $signed(cfg_wdata[21:0]);
        CFG_PERIOD:    period    <= cfg_wdata[19:0];
        CFG_MIN_RANGE: min_range <= cfg_wdata;
        CFG_MAX_RANGE: max_range <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lrt_mult u_mult (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  lrt_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .n(rxy << (2*SH)),
    .done(sqrt_done), .root(rho)
  );

  lrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .done(c_done), .z(c_z)
  );

  lrt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num_mag), .den(den_mag),
    .done(div_done), .q(div_q)
  );

  always_comb begin
    logic [63:0] r3;
    r3 = rxy + zz;
    range_keep = !(r3 < mnsq || r3 > prod[63:0]);
  end

  always_comb begin
    logic signed [47:0] pr;
    logic signed [47:0] ar;
    logic signed [31:0] adeg;
    pr = prod[47:0];
    ar = (pr + 48'sd32768) >>> 16;
    adeg = $signed(ar[31:0]);
    ring_val = '0;
    ring_ok  = 1'b0;
    unique case (ring_mode)
      RING_16: begin
        ring_val = tdiv(adeg + 32'sd1048576, 5'd17);
        ring_ok  = ring_val >= 0 && ring_val <= 32'sd15;
      end
      RING_32: begin
        ring_val = tdiv(32'sd3 * adeg + 32'sd6029312, 5'd18);
        ring_ok  = ring_val >= 0 && ring_val <= 32'sd31;
      end
      RING_64: begin
        if (adeg >= DEG_M883) begin
          ring_val = tdiv(32'sd3 * (DEG_2 - adeg) + 32'sd32768, 5'd16);
        end else begin
          ring_val = 32'sd32 + tdiv(32'sd2 * (DEG_M883 - adeg) + 32'sd32768, 5'd16);
        end
        ring_ok = !(adeg > DEG_2 || adeg < DEG_M2433 || ring_val > 32'sd50 || ring_val < 0);
      end
      default: begin
        ring_val = '0;
        ring_ok  = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic signed [OW-1:0] s_e;
    logic signed [OW-1:0] e_e;
    logic signed [OW-1:0] o;
    s_e = OW'(start_az);
    e_e = OW'(end_az);
    o   = -OW'(c_z);
    hp_next = half_passed;
    if (!half_passed) begin
      if (o < s_e - O_HALF_PI) begin
        o = o + O_2PI;
      end else if (o > s_e + O_3HALF_PI) begin
        o = o - O_2PI;
      end
      if (o - s_e > O_PI) begin
        hp_next = 1'b1;
      end
    end else begin
      o = o + O_2PI;
      if (o < e_e - O_3HALF_PI) begin
        o = o + O_2PI;
      end else if (o > e_e + O_HALF_PI) begin
        o = o - O_2PI;
      end
    end
    ori_u = o;
  end

  always_comb begin
    den     = DW'(end_az) - DW'(start_az);
    den_mag = (den < 0) ? DW'(-den) : DW'(den);
    num     = prod[NW-1:0];
    num_mag = (num < 0) ? NW'(-num) : NW'(num);
    t_sat   = num_mag >= NW'({den_mag, {QB{1'b0}}});
    q_signed = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (q_signed > (TW+1)'(T_MAX)) begin
      q_final = T_MAX;
    end else if (q_signed < (TW+1)'(T_MIN)) begin
      q_final = T_MIN;
    end else begin
      q_final = q_signed[TW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_fire) state_next = S_SQ_X;
      S_SQ_X:   state_next = S_SQ_Y;
      S_SQ_Y:   state_next = S_SQ_Z;
      S_SQ_Z:   state_next = S_SQ_MN;
      S_SQ_MN:  state_next = S_SQ_MX;
      S_SQ_MX:  state_next = S_RANGE;
      S_RANGE:  state_next = (range_keep && ring_mode != RING_OFF) ? S_SQRT : S_IDLE;
      S_SQRT:   if (sqrt_done) state_next = S_ELEV;
      S_ELEV:   if (c_done) state_next = S_DEG;
      S_DEG:    state_next = S_RING;
      S_RING:   state_next = ring_ok ? S_AZ : S_IDLE;
      S_AZ:     if (c_done) state_next = S_UNWRAP;
      S_UNWRAP: state_next = S_TMUL;
      S_TMUL:   state_next = S_TCHK;
      S_TCHK:   state_next = (den != 0 && !t_sat) ? S_DIV : S_OUT;
      S_DIV:    if (div_done) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == S_IDLE);
    sqrt_start = (state == S_RANGE) && range_keep && ring_mode != RING_OFF;
    div_start  = (state == S_TCHK) && den != 0 && !t_sat;
    creq.start = 1'b0;
    creq.x     = '0;
    creq.y     = '0;
    if (state == S_SQRT) begin
      creq.start = sqrt_done;
      creq.x     = $signed({{(CW-32){1'b0}}, rho});
      creq.y     = CW'(pz_r) <<< SH;
    end else if (state == S_RING) begin
      creq.start = ring_ok;
      creq.x     = CW'(px_r) <<< SH;
      creq.y     = CW'(py_r) <<< SH;
    end
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ_X:  begin mul_a = MW'(px_r); mul_b = MW'(px_r); end
      S_SQ_Y:  begin mul_a = MW'(py_r); mul_b = MW'(py_r); end
      S_SQ_Z:  begin mul_a = MW'(pz_r); mul_b = MW'(pz_r); end
      S_SQ_MN: begin
        mul_a = $signed({{(MW-23){1'b0}}, min_range});
        mul_b = $signed({{(MW-23){1'b0}}, min_range});
      end
      S_SQ_MX: begin
        mul_a = $signed({{(MW-23){1'b0}}, max_range});
        mul_b = $signed({{(MW-23){1'b0}}, max_range});
      end
      S_DEG:   begin mul_a = MW'(c_z); mul_b = DEG_PER_RAD; end
      S_TMUL:  begin mul_a = $signed({{(MW-20){1'b0}}, period}); mul_b = MW'(diff); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      half_passed <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_fire && s_tuser) begin
        half_passed <= 1'b0;
      end
      if (state == S_UNWRAP) begin
        half_passed <= hp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      px_r    <= $signed(s_tdata[CB-1:0]);
      py_r    <= $signed(s_tdata[2*CB-1:CB]);
      pz_r    <= $signed(s_tdata[3*CB-1:2*CB]);
      inten_r <= s_tdata[3*CB+15:3*CB];
    end
    unique case (state)
      S_SQ_Y:   rxy  <= prod[63:0];
      S_SQ_Z:   rxy  <= rxy + prod[63:0];
      S_SQ_MN:  zz   <= prod[63:0];
      S_SQ_MX:  mnsq <= prod[63:0];
      S_RING:   ring_r <= ring_val[RW-1:0];
      S_UNWRAP: diff <= ori_u - OW'(start_az);
      S_TCHK: begin
        neg_r <= (num < 0) != (den < 0);
        if (den == 0) begin
          t_r <= '0;
        end else if (t_sat) begin
          t_r <= ((num < 0) != (den < 0)) ? T_MIN : T_MAX;
        end
      end
      S_DIV:    if (div_done) t_r <= q_final;
      S_OUT: begin
        if (out_free) begin
          oqx    <= px_r;
          oqy    <= py_r;
          oqz    <= pz_r;
          ointen <= inten_r;
          oring  <= ring_r;
          otime  <= t_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_F-1:0] = {otime, oring, ointen, oqz, oqy, oqx};
  end

endmodule
